### rtl/core/contact_impulse_resolver_top_macros.svh
// Assertion macros shared by the resolver RTL.
`ifndef CONTACT_IMPULSE_RESOLVER_TOP_MACROS_SVH
`define CONTACT_IMPULSE_RESOLVER_TOP_MACROS_SVH
// Property checked on every rising clock edge outside reset.
`define CIR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Property checked on every rising clock edge, reset cycles included.
`define CIR_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`endif

### rtl/core/cir_pkg.sv
// Shared fixed-point types, constants and saturation helper of the contact resolver.
package cir_pkg;
   typedef logic signed [31:0] fix_type;

   localparam fix_type FIX_MAX = 32'sh7fffffff;
   localparam fix_type FIX_MIN = 32'sh80000000;

   // Bit positions inside the freeze flags.
   localparam int FRZ_AX = 0;
   localparam int FRZ_AY = 1;
   localparam int FRZ_BX = 2;
   localparam int FRZ_BY = 3;

   function automatic fix_type cir_sat(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return FIX_MAX;
      end
      if (v < -64'sd2147483648) begin
         return FIX_MIN;
      end
      return fix_type'(v[31:0]);
   endfunction
endpackage

### rtl/core/cir_dly.sv
// Stallable delay line that carries an item's context and valid bit beside a unit.
module cir_dly #(
   parameter int W     = 8,
   parameter int DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         vld_i,
   input  logic [W-1:0] d_i,
   output logic         vld_o,
   output logic [W-1:0] d_o
);
   logic [W-1:0] data_ff [0:DEPTH-1];
   logic         vld_ff  [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff[0] <= d_i;
         for (int i = 1; i < DEPTH; i++) begin
            data_ff[i] <= data_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= vld_i;
         for (int i = 1; i < DEPTH; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   assign vld_o = vld_ff[DEPTH-1];
   assign d_o   = data_ff[DEPTH-1];
endmodule

### rtl/core/cir_sqrt.sv
// Pipelined integer square root, one result bit per stage, 64-bit radicand.
module cir_sqrt import cir_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] rad,
   output logic [31:0] root
);
   localparam int STEPS = 32;

   logic [63:0] rad_ff  [0:STEPS];
   logic [33:0] rem_ff  [0:STEPS];
   logic [31:0] root_ff [0:STEPS];
   logic [63:0] rad_in  [1:STEPS];
   logic [33:0] rem_in  [1:STEPS];
   logic [31:0] root_in [1:STEPS];
   logic [35:0] part    [1:STEPS];
   logic [35:0] trial   [1:STEPS];

   // Each step brings down two radicand bits and tries the next root bit.
   always_comb begin
      for (int s = 1; s <= STEPS; s++) begin
         part[s]   = {rem_ff[s-1], rad_ff[s-1][63:62]};
         trial[s]  = {2'b00, root_ff[s-1], 2'b01};
         rad_in[s] = {rad_ff[s-1][61:0], 2'b00};
         if (part[s] >= trial[s]) begin
            rem_in[s]  = 34'(part[s] - trial[s]);
            root_in[s] = {root_ff[s-1][30:0], 1'b1};
         end else begin
            rem_in[s]  = part[s][33:0];
            root_in[s] = {root_ff[s-1][30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff[0]  <= rad;
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         for (int s = 1; s <= STEPS; s++) begin
            rad_ff[s]  <= rad_in[s];
            rem_ff[s]  <= rem_in[s];
            root_ff[s] <= root_in[s];
         end
      end
   end

   assign root = root_ff[STEPS];
endmodule

### rtl/core/cir_div.sv
// Pipelined fixed-point divider: saturated (num << FRAC_BITS) / den, truncated toward zero.
module cir_div import cir_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        en,
   input  fix_type     num,
   input  logic [31:0] den,
   output fix_type     quot
);
   localparam int NW = 32 + FRAC_BITS;

   logic [NW-1:0] dv_ff   [0:NW];
   logic [31:0]   rem_ff  [0:NW];
   logic [31:0]   den_ff  [0:NW];
   logic          neg_ff  [0:NW];
   logic          zero_ff [0:NW];
   logic [NW-1:0] dv_in   [1:NW];
   logic [31:0]   rem_in  [1:NW];
   logic [32:0]   part    [1:NW];
   logic [31:0]   mag;
   fix_type       quot_in;
   fix_type       quot_ff;

   always_comb begin
      mag = num[31] ? 32'(-num) : 32'(num);
   end

   // Restoring division: one quotient bit per stage, shifted into the dividend word.
   always_comb begin
      for (int s = 1; s <= NW; s++) begin
         part[s] = {rem_ff[s-1], dv_ff[s-1][NW-1]};
         if (part[s] >= {1'b0, den_ff[s-1]}) begin
            rem_in[s] = 32'(part[s] - {1'b0, den_ff[s-1]});
            dv_in[s]  = {dv_ff[s-1][NW-2:0], 1'b1};
         end else begin
            rem_in[s] = part[s][31:0];
            dv_in[s]  = {dv_ff[s-1][NW-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      if (zero_ff[NW]) begin
         quot_in = '0;
      end else if (!neg_ff[NW]) begin
         quot_in = (dv_ff[NW] > NW'(32'h7fffffff)) ? FIX_MAX : fix_type'(dv_ff[NW][31:0]);
      end else begin
         quot_in = (dv_ff[NW] > NW'(33'h080000000)) ? FIX_MIN :
                   fix_type'(-dv_ff[NW][31:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_ff[0]   <= {mag, FRAC_BITS'(0)};
         rem_ff[0]  <= '0;
         den_ff[0]  <= den;
         neg_ff[0]  <= num[31];
         zero_ff[0] <= (den == '0);
         for (int s = 1; s <= NW; s++) begin
            dv_ff[s]   <= dv_in[s];
            rem_ff[s]  <= rem_in[s];
            den_ff[s]  <= den_ff[s-1];
            neg_ff[s]  <= neg_ff[s-1];
            zero_ff[s] <= zero_ff[s-1];
         end
         quot_ff <= quot_in;
      end
   end

   assign quot = quot_ff;
endmodule

### rtl/core/contact_impulse_resolver_top.sv
// Top level of the contact resolver: a deep pipeline that resolves one contact per item.
//
// Usage: an item on the req_ channel describes one contact between bodies A and B;
// the rsp_ channel returns one item per input item, in order. Both channels hand over
// an item when tvalid and tready are high at a rising clock edge. req_tuser carries
// the trigger mark and rsp_tuser the resolved flag.
// The path from acceptance to rsp_tvalid runs through a chain of two square-root
// units (33 stages each) and four divider units (FRAC_BITS + 34 stages each), which
// follow one another because each needs the previous result.
// Throughput: one item per cycle while the receiver does not stall the output; every
// unit is fully pipelined.
// Reset (synchronous, active high) clears every valid bit, so the pipeline is empty
// and rsp_tvalid is low afterwards.
// Stall: the result sits in an output register. When the receiver holds tready low,
// the pipeline keeps moving as long as its last stage is empty, so input items are
// still taken; once the last stage holds an item the whole pipeline freezes, and
// nothing is lost or repeated.
`include "contact_impulse_resolver_top_macros.svh"
module contact_impulse_resolver_top import cir_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // From bit 0: vel_a[64], vel_b[64], contact_normal[64], penetration[32],
   // inv_mass_a[31], inv_mass_b[31], restitution_a[32], restitution_b[32],
   // friction_a[32], friction_b[32], freeze_flags[4], zero fill[6].
   input  logic [423:0] req_tdata,
   // Bit 0: is_trigger.
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // From bit 0: new_vel_a[64], new_vel_b[64], shift_a[64], shift_b[64].
   output logic [255:0] rsp_tdata,
   // Bit 0: resolved.
   output logic [0:0]   rsp_tuser
);
   localparam int DIV_LAT = 32 + FRAC_BITS + 2;
   localparam int SQ_LAT  = 33;

   localparam fix_type ONE  = fix_type'(64'd1 << FRAC_BITS);
   localparam fix_type PCT  = fix_type'(((64'd1 << FRAC_BITS) * 4 + 2) / 5);
   localparam fix_type SLOP = fix_type'(((64'd1 << FRAC_BITS) + 50) / 100);
   // Squared-length floor, with twice the fractional bits.
   localparam logic [63:0] MIN_LSQ = ((64'd1 << (2 * FRAC_BITS)) + 64'd500000) / 64'd1000000;

   // Everything an item carries down the pipeline. Several fields are reused by
   // later steps once their first value has been consumed.
   typedef struct packed {
      fix_type     vax, vay, vbx, vby;
      fix_type     cx, cy;
      fix_type     ima, imb;
      fix_type     e, vrx, vry, depth, sum;
      logic [3:0]  fr;
      logic        trig, skip, approach, fric;
      logic [63:0] sqx, sqy, lsq, prod_u;
      logic [31:0] len;
      fix_type     mu, nx, ny, cq, c, p1, p2, van, ope, t;
      fix_type     kx, ky, nkx, nky, sax, say, sbx, sby;
      fix_type     dn, j, ix, iy, mx, nmx, dax, day, dbx, dby;
      fix_type     va1x, va1y, vb1x, vb1y, rx, ry, d, tx, ty, ux, uy, fm;
   } ctx_type;

   localparam int CW = $bits(ctx_type);

   function automatic fix_type mulf(input fix_type a, input fix_type b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b);
      return cir_sat(p >>> FRAC_BITS);
   endfunction

   // Pipeline control: a bubble in the last stage may be dropped while the output waits.
   logic en;
   logic out_load;
   logic out_vld_ff;
   logic [255:0] out_data_ff, out_data_in;
   logic out_res_ff, out_res_in;

   ctx_type r1_in, r1_ff, r2_in, r2_ff, r3_in, r3_ff, r4_in, r4_ff, r5_in, r5_ff;
   ctx_type r6_in, r6_ff, r7_in, r7_ff, r8_in, r8_ff, r9_in, r9_ff, r10_in, r10_ff;
   ctx_type r11_in, r11_ff, r12_in, r12_ff, r13_in, r13_ff, r14_in, r14_ff;
   ctx_type r15_in, r15_ff, r16_in, r16_ff, r17_in, r17_ff, r18_in, r18_ff;
   ctx_type r19_in, r19_ff, r20_in, r20_ff, r21_in, r21_ff, r22_in, r22_ff;
   ctx_type r23_in, r23_ff, r24_in, r24_ff, r25_in, r25_ff, r26_in, r26_ff;
   logic r1_vld_ff, r2_vld_ff, r3_vld_ff, r4_vld_ff, r5_vld_ff, r6_vld_ff, r7_vld_ff;
   logic r8_vld_ff, r9_vld_ff, r10_vld_ff, r11_vld_ff, r12_vld_ff, r13_vld_ff;
   logic r14_vld_ff, r15_vld_ff, r16_vld_ff, r17_vld_ff, r18_vld_ff, r19_vld_ff;
   logic r20_vld_ff, r21_vld_ff, r22_vld_ff, r23_vld_ff, r24_vld_ff, r25_vld_ff;
   logic r26_vld_ff;

   ctx_type d1_ctx, d2_ctx, d3_ctx, d4_ctx, d5_ctx, d6_ctx;
   logic d1_vld, d2_vld, d3_vld, d4_vld, d5_vld, d6_vld;
   logic [31:0] len_root, mu_root, tlen_root;
   fix_type nx_q, ny_q, cq_q, j_q, ux_q, uy_q, fm_q;

   assign out_load   = rsp_tready | ~out_vld_ff;
   assign en         = out_load | ~r26_vld_ff;
   assign req_tready = en;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_res_ff;

   // Stage 1: unpack, squares of the normal, friction product, simple sums.
   always_comb begin
      fix_type vax, vay, vbx, vby, cx, cy, pen, ra, rb, fa, fb, ima, imb, dr;
      logic signed [63:0] prod;
      vax = fix_type'(req_tdata[63:32]);
      vay = fix_type'(req_tdata[31:0]);
      vbx = fix_type'(req_tdata[127:96]);
      vby = fix_type'(req_tdata[95:64]);
      cx  = fix_type'(req_tdata[191:160]);
      cy  = fix_type'(req_tdata[159:128]);
      pen = fix_type'(req_tdata[223:192]);
      ima = fix_type'({1'b0, req_tdata[254:224]});
      imb = fix_type'({1'b0, req_tdata[285:255]});
      ra  = fix_type'(req_tdata[317:286]);
      rb  = fix_type'(req_tdata[349:318]);
      fa  = fix_type'(req_tdata[381:350]);
      fb  = fix_type'(req_tdata[413:382]);
      dr  = cir_sat(64'(pen) - 64'(SLOP));
      prod = 64'(fa) * 64'(fb);
      r1_in = '0;
      r1_in.vax = vax;
      r1_in.vay = vay;
      r1_in.vbx = vbx;
      r1_in.vby = vby;
      r1_in.cx = cx;
      r1_in.cy = cy;
      r1_in.ima = ima;
      r1_in.imb = imb;
      r1_in.sum = cir_sat(64'(ima) + 64'(imb));
      r1_in.e = (ra < rb) ? ra : rb;
      r1_in.vrx = cir_sat(64'(vbx) - 64'(vax));
      r1_in.vry = cir_sat(64'(vby) - 64'(vay));
      r1_in.depth = (dr < 0) ? '0 : dr;
      r1_in.fr = req_tdata[417:414];
      r1_in.trig = req_tuser[0];
      r1_in.sqx = $unsigned(64'(cx) * 64'(cx));
      r1_in.sqy = $unsigned(64'(cy) * 64'(cy));
      r1_in.prod_u = (prod <= 0) ? '0 : $unsigned(prod);
   end

   // Stage 2: squared normal length and the skip decision.
   always_comb begin
      r2_in = r1_ff;
      r2_in.lsq = r1_ff.sqx + r1_ff.sqy;
      r2_in.skip = r1_ff.trig | (r2_in.lsq <= MIN_LSQ) | (r1_ff.sum == '0);
   end

   cir_sqrt u_sq_len (.clock(clock), .en(en), .rad(r2_ff.lsq), .root(len_root));
   cir_sqrt u_sq_mu  (.clock(clock), .en(en), .rad(r2_ff.prod_u), .root(mu_root));
   cir_dly #(.W(CW), .DEPTH(SQ_LAT)) u_dly1 (
      .clock(clock), .reset(reset), .en(en), .vld_i(r2_vld_ff), .d_i(r2_ff),
      .vld_o(d1_vld), .d_o(d1_ctx));

   always_comb begin
      r3_in = d1_ctx;
      r3_in.len = (len_root == '0) ? 32'd1 : len_root;
      r3_in.mu = mu_root[31] ? FIX_MAX : fix_type'(mu_root);
   end

   cir_div #(.FRAC_BITS(FRAC_BITS)) u_div_nx (
      .clock(clock), .en(en), .num(r3_ff.cx), .den(r3_ff.len), .quot(nx_q));
   cir_div #(.FRAC_BITS(FRAC_BITS)) u_div_ny (
      .clock(clock), .en(en), .num(r3_ff.cy), .den(r3_ff.len), .quot(ny_q));
   cir_div #(.FRAC_BITS(FRAC_BITS)) u_div_cq (
      .clock(clock), .en(en), .num(r3_ff.depth), .den(32'(r3_ff.sum)), .quot(cq_q));
   cir_dly #(.W(CW), .DEPTH(DIV_LAT)) u_dly2 (
      .clock(clock), .reset(reset), .en(en), .vld_i(r3_vld_ff), .d_i(r3_ff),
      .vld_o(d2_vld), .d_o(d2_ctx));

   // Unit normal known: normal velocity products and correction scale.
   always_comb begin
      r4_in = d2_ctx;
      r4_in.nx = nx_q;
      r4_in.ny = ny_q;
      r4_in.cq = cq_q;
      r4_in.p1 = mulf(d2_ctx.vrx, nx_q);
      r4_in.p2 = mulf(d2_ctx.vry, ny_q);
      r4_in.c = mulf(cq_q, PCT);
   end

   always_comb begin
      r5_in = r4_ff;
      r5_in.van = cir_sat(64'(r4_ff.p1) + 64'(r4_ff.p2));
      r5_in.ope = cir_sat(64'(ONE) + 64'(r4_ff.e));
      r5_in.approach = (r5_in.van <= 0);
   end

   always_comb begin
      r6_in = r5_ff;
      r6_in.t = mulf(r5_ff.ope, r5_ff.van);
      r6_in.kx = mulf(r5_ff.nx, r5_ff.c);
      r6_in.ky = mulf(r5_ff.ny, r5_ff.c);
   end

   always_comb begin
      r7_in = r6_ff;
      r7_in.dn = cir_sat(-64'(r6_ff.t));
      r7_in.nkx = cir_sat(-64'(r6_ff.kx));
      r7_in.nky = cir_sat(-64'(r6_ff.ky));
   end

   // Positional corrections, with frozen axes forced to zero.
   always_comb begin
      r8_in = r7_ff;
      r8_in.sax = r7_ff.fr[FRZ_AX] ? '0 : mulf(r7_ff.nkx, r7_ff.ima);
      r8_in.say = r7_ff.fr[FRZ_AY] ? '0 : mulf(r7_ff.nky, r7_ff.ima);
      r8_in.sbx = r7_ff.fr[FRZ_BX] ? '0 : mulf(r7_ff.kx, r7_ff.imb);
      r8_in.sby = r7_ff.fr[FRZ_BY] ? '0 : mulf(r7_ff.ky, r7_ff.imb);
   end

   cir_div #(.FRAC_BITS(FRAC_BITS)) u_div_j (
      .clock(clock), .en(en), .num(r8_ff.dn), .den(32'(r8_ff.sum)), .quot(j_q));
   cir_dly #(.W(CW), .DEPTH(DIV_LAT)) u_dly3 (
      .clock(clock), .reset(reset), .en(en), .vld_i(r8_vld_ff), .d_i(r8_ff),
      .vld_o(d3_vld), .d_o(d3_ctx));

   // Restitution impulse and the friction bound.
   always_comb begin
      r9_in = d3_ctx;
      r9_in.j = j_q;
      r9_in.ix = mulf(d3_ctx.nx, j_q);
      r9_in.iy = mulf(d3_ctx.ny, j_q);
      r9_in.mx = mulf(j_q, d3_ctx.mu);
   end

   always_comb begin
      r10_in = r9_ff;
      r10_in.dax = mulf(r9_ff.ix, r9_ff.ima);
      r10_in.day = mulf(r9_ff.iy, r9_ff.ima);
      r10_in.dbx = mulf(r9_ff.ix, r9_ff.imb);
      r10_in.dby = mulf(r9_ff.iy, r9_ff.imb);
      r10_in.nmx = cir_sat(-64'(r9_ff.mx));
   end

   always_comb begin
      r11_in = r10_ff;
      r11_in.va1x = cir_sat(64'(r10_ff.vax) - 64'(r10_ff.dax));
      r11_in.va1y = cir_sat(64'(r10_ff.vay) - 64'(r10_ff.day));
      r11_in.vb1x = cir_sat(64'(r10_ff.vbx) + 64'(r10_ff.dbx));
      r11_in.vb1y = cir_sat(64'(r10_ff.vby) + 64'(r10_ff.dby));
   end

   always_comb begin
      r12_in = r11_ff;
      r12_in.rx = cir_sat(64'(r11_ff.vb1x) - 64'(r11_ff.va1x));
      r12_in.ry = cir_sat(64'(r11_ff.vb1y) - 64'(r11_ff.va1y));
   end

   always_comb begin
      r13_in = r12_ff;
      r13_in.p1 = mulf(r12_ff.rx, r12_ff.nx);
      r13_in.p2 = mulf(r12_ff.ry, r12_ff.ny);
   end

   always_comb begin
      r14_in = r13_ff;
      r14_in.d = cir_sat(64'(r13_ff.p1) + 64'(r13_ff.p2));
   end

   always_comb begin
      r15_in = r14_ff;
      r15_in.p1 = mulf(r14_ff.nx, r14_ff.d);
      r15_in.p2 = mulf(r14_ff.ny, r14_ff.d);
   end

   // Tangent of the relative velocity.
   always_comb begin
      r16_in = r15_ff;
      r16_in.tx = cir_sat(64'(r15_ff.rx) - 64'(r15_ff.p1));
      r16_in.ty = cir_sat(64'(r15_ff.ry) - 64'(r15_ff.p2));
   end

   always_comb begin
      r17_in = r16_ff;
      r17_in.sqx = $unsigned(64'(r16_ff.tx) * 64'(r16_ff.tx));
      r17_in.sqy = $unsigned(64'(r16_ff.ty) * 64'(r16_ff.ty));
   end

   always_comb begin
      r18_in = r17_ff;
      r18_in.lsq = r17_ff.sqx + r17_ff.sqy;
      r18_in.fric = (r18_in.lsq > MIN_LSQ);
   end

   cir_sqrt u_sq_tan (.clock(clock), .en(en), .rad(r18_ff.lsq), .root(tlen_root));
   cir_dly #(.W(CW), .DEPTH(SQ_LAT)) u_dly4 (
      .clock(clock), .reset(reset), .en(en), .vld_i(r18_vld_ff), .d_i(r18_ff),
      .vld_o(d4_vld), .d_o(d4_ctx));

   always_comb begin
      r19_in = d4_ctx;
      r19_in.len = (tlen_root == '0) ? 32'd1 : tlen_root;
   end

   cir_div #(.FRAC_BITS(FRAC_BITS)) u_div_ux (
      .clock(clock), .en(en), .num(r19_ff.tx), .den(r19_ff.len), .quot(ux_q));
   cir_div #(.FRAC_BITS(FRAC_BITS)) u_div_uy (
      .clock(clock), .en(en), .num(r19_ff.ty), .den(r19_ff.len), .quot(uy_q));
   cir_dly #(.W(CW), .DEPTH(DIV_LAT)) u_dly5 (
      .clock(clock), .reset(reset), .en(en), .vld_i(r19_vld_ff), .d_i(r19_ff),
      .vld_o(d5_vld), .d_o(d5_ctx));

   always_comb begin
      r20_in = d5_ctx;
      r20_in.ux = ux_q;
      r20_in.uy = uy_q;
      r20_in.p1 = mulf(d5_ctx.rx, ux_q);
      r20_in.p2 = mulf(d5_ctx.ry, uy_q);
   end

   always_comb begin
      r21_in = r20_ff;
      r21_in.d = cir_sat(64'(r20_ff.p1) + 64'(r20_ff.p2));
   end

   always_comb begin
      r22_in = r21_ff;
      r22_in.dn = cir_sat(-64'(r21_ff.d));
   end

   cir_div #(.FRAC_BITS(FRAC_BITS)) u_div_fm (
      .clock(clock), .en(en), .num(r22_ff.dn), .den(32'(r22_ff.sum)), .quot(fm_q));
   cir_dly #(.W(CW), .DEPTH(DIV_LAT)) u_dly6 (
      .clock(clock), .reset(reset), .en(en), .vld_i(r22_vld_ff), .d_i(r22_ff),
      .vld_o(d6_vld), .d_o(d6_ctx));

   // Coulomb clamp; the lower bound is tested first, which matters when the bound is negative.
   always_comb begin
      r23_in = d6_ctx;
      priority if (fm_q < d6_ctx.nmx) begin
         r23_in.fm = d6_ctx.nmx;
      end else if (fm_q > d6_ctx.mx) begin
         r23_in.fm = d6_ctx.mx;
      end else begin
         r23_in.fm = fm_q;
      end
   end

   always_comb begin
      r24_in = r23_ff;
      r24_in.ix = mulf(r23_ff.ux, r23_ff.fm);
      r24_in.iy = mulf(r23_ff.uy, r23_ff.fm);
   end

   always_comb begin
      r25_in = r24_ff;
      r25_in.dax = mulf(r24_ff.ix, r24_ff.ima);
      r25_in.day = mulf(r24_ff.iy, r24_ff.ima);
      r25_in.dbx = mulf(r24_ff.ix, r24_ff.imb);
      r25_in.dby = mulf(r24_ff.iy, r24_ff.imb);
   end

   always_comb begin
      r26_in = r25_ff;
      if (r25_ff.fric) begin
         r26_in.va1x = cir_sat(64'(r25_ff.va1x) - 64'(r25_ff.dax));
         r26_in.va1y = cir_sat(64'(r25_ff.va1y) - 64'(r25_ff.day));
         r26_in.vb1x = cir_sat(64'(r25_ff.vb1x) + 64'(r25_ff.dbx));
         r26_in.vb1y = cir_sat(64'(r25_ff.vb1y) + 64'(r25_ff.dby));
      end
   end

   // Result selection: a skipped contact echoes its velocities; receding bodies keep theirs.
   always_comb begin
      logic [63:0] va, vb, sa, sb;
      va = {r26_ff.vax, r26_ff.vay};
      vb = {r26_ff.vbx, r26_ff.vby};
      sa = '0;
      sb = '0;
      out_res_in = 1'b0;
      if (!r26_ff.skip) begin
         out_res_in = 1'b1;
         sa = {r26_ff.sax, r26_ff.say};
         sb = {r26_ff.sbx, r26_ff.sby};
         if (r26_ff.approach) begin
            va = {r26_ff.va1x, r26_ff.va1y};
            vb = {r26_ff.vb1x, r26_ff.vb1y};
         end
      end
      out_data_in = {sb, sa, vb, va};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r1_ff <= r1_in;
         r2_ff <= r2_in;
         r3_ff <= r3_in;
         r4_ff <= r4_in;
         r5_ff <= r5_in;
         r6_ff <= r6_in;
         r7_ff <= r7_in;
         r8_ff <= r8_in;
         r9_ff <= r9_in;
         r10_ff <= r10_in;
         r11_ff <= r11_in;
         r12_ff <= r12_in;
         r13_ff <= r13_in;
         r14_ff <= r14_in;
         r15_ff <= r15_in;
         r16_ff <= r16_in;
         r17_ff <= r17_in;
         r18_ff <= r18_in;
         r19_ff <= r19_in;
         r20_ff <= r20_in;
         r21_ff <= r21_in;
         r22_ff <= r22_in;
         r23_ff <= r23_in;
         r24_ff <= r24_in;
         r25_ff <= r25_in;
         r26_ff <= r26_in;
      end
      if (out_load) begin
         out_data_ff <= out_data_in;
         out_res_ff <= out_res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r1_vld_ff <= 1'b0;
         r2_vld_ff <= 1'b0;
         r3_vld_ff <= 1'b0;
         r4_vld_ff <= 1'b0;
         r5_vld_ff <= 1'b0;
         r6_vld_ff <= 1'b0;
         r7_vld_ff <= 1'b0;
         r8_vld_ff <= 1'b0;
         r9_vld_ff <= 1'b0;
         r10_vld_ff <= 1'b0;
         r11_vld_ff <= 1'b0;
         r12_vld_ff <= 1'b0;
         r13_vld_ff <= 1'b0;
         r14_vld_ff <= 1'b0;
         r15_vld_ff <= 1'b0;
         r16_vld_ff <= 1'b0;
         r17_vld_ff <= 1'b0;
         r18_vld_ff <= 1'b0;
         r19_vld_ff <= 1'b0;
         r20_vld_ff <= 1'b0;
         r21_vld_ff <= 1'b0;
         r22_vld_ff <= 1'b0;
         r23_vld_ff <= 1'b0;
         r24_vld_ff <= 1'b0;
         r25_vld_ff <= 1'b0;
         r26_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (en) begin
            r1_vld_ff <= req_tvalid;
            r2_vld_ff <= r1_vld_ff;
            r3_vld_ff <= d1_vld;
            r4_vld_ff <= d2_vld;
            r5_vld_ff <= r4_vld_ff;
            r6_vld_ff <= r5_vld_ff;
            r7_vld_ff <= r6_vld_ff;
            r8_vld_ff <= r7_vld_ff;
            r9_vld_ff <= d3_vld;
            r10_vld_ff <= r9_vld_ff;
            r11_vld_ff <= r10_vld_ff;
            r12_vld_ff <= r11_vld_ff;
            r13_vld_ff <= r12_vld_ff;
            r14_vld_ff <= r13_vld_ff;
            r15_vld_ff <= r14_vld_ff;
            r16_vld_ff <= r15_vld_ff;
            r17_vld_ff <= r16_vld_ff;
            r18_vld_ff <= r17_vld_ff;
            r19_vld_ff <= d4_vld;
            r20_vld_ff <= d5_vld;
            r21_vld_ff <= r20_vld_ff;
            r22_vld_ff <= r21_vld_ff;
            r23_vld_ff <= d6_vld;
            r24_vld_ff <= r23_vld_ff;
            r25_vld_ff <= r24_vld_ff;
            r26_vld_ff <= r25_vld_ff;
         end
         if (out_load) begin
            out_vld_ff <= r26_vld_ff;
         end
      end
   end

   // A skipped contact never carries a position correction.
   `CIR_ASSERT(a_skip_no_shift, out_vld_ff && !out_res_ff |-> out_data_ff[255:128] == '0, "skipped item carries a correction")
   // A finished item that cannot move into the output register must stay in the last stage.
   `CIR_ASSERT(a_last_holds, r26_vld_ff && !out_load |=> r26_vld_ff, "finished item dropped during stall")
   // Reset empties the pipeline entrance and the output register.
   `CIR_ASSERT_ALWAYS(a_reset_empty, reset |=> !out_vld_ff && !r1_vld_ff, "pipeline not empty after reset")
endmodule

### test/tb.sv
// Testbench for contact_impulse_resolver_top: random and directed contacts checked against a predictor.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cir_pkg::*;

   localparam int FB = 16;
   localparam longint ONE = longint'(1) << FB;
   localparam longint PCT = (ONE * 4 + 2) / 5;
   localparam longint SLOP = (ONE + 50) / 100;
   localparam longint MIN_LSQ = ((longint'(1) << (2 * FB)) + 500000) / 1000000;
   // Allow a margin when draining the pipeline.
   localparam int DRAIN_CYCLES = 400;
   localparam longint CYCLE_LIMIT = 400000;

   // One contact as it enters the block.
   typedef struct {
      logic [63:0] vel_a, vel_b, normal;
      logic [31:0] pen;
      logic [30:0] ima, imb;
      logic [31:0] rest_a, rest_b, fric_a, fric_b;
      logic [3:0]  frz;
      logic        trig;
   } contact_type;

   // One resolved contact as it leaves the block.
   typedef struct {
      logic [63:0] vel_a, vel_b, shift_a, shift_b;
      logic        resolved;
   } outcome_type;

   // Scoreboard: predicts each accepted contact and checks outcomes in order.
   class contact_scoreboard;
      outcome_type pending_q[$];
      int errors;

      function new();
         errors = 0;
      endfunction

      static function longint clamp32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      static function longint fmul(longint a, longint b);
         return clamp32((a * b) >>> FB);
      endfunction

      static function longint fdiv(longint a, longint b);
         if (b == 0) return 0;
         return clamp32((a * ONE) / b);
      endfunction

      static function longint unsigned root(longint unsigned v);
         longint unsigned res, bitv;
         res = 0;
         bitv = 64'd1 << 62;
         while (bitv > v) bitv >>= 2;
         while (bitv != 0) begin
            if (v >= res + bitv) begin
               v -= res + bitv;
               res = (res >> 1) + bitv;
            end else begin
               res >>= 1;
            end
            bitv >>= 2;
         end
         return res;
      endfunction

      static function longint unsigned len_sq(longint x, longint y);
         return longint'(x * x) + longint'(y * y);
      endfunction

      static function void unit_vec(longint x, longint y, longint unsigned lsq,
                                    output longint ox, output longint oy);
         longint len;
         len = longint'(root(lsq));
         if (len == 0) len = 1;
         ox = clamp32((x * ONE) / len);
         oy = clamp32((y * ONE) / len);
      endfunction

      static function longint dot(longint ax, longint ay, longint bx, longint by);
         return clamp32(fmul(ax, bx) + fmul(ay, by));
      endfunction

      static function longint s32(logic [31:0] v);
         return longint'($signed(v));
      endfunction

      static function logic [63:0] pack2(longint x, longint y);
         return {x[31:0], y[31:0]};
      endfunction

      static function outcome_type resolve(contact_type c);
         outcome_type o;
         longint vax, vay, vbx, vby, cx, cy, pen, ima, imb, ra, rb, fa, fb;
         longint nx, ny, sum, van, depth, cc, kx, ky, sax, say, sbx, sby;
         longint e, j, ix, iy, rx, ry, d, tx, ty, ux, uy, fm, mu, mx, prod;
         longint unsigned lsq, tl;
         vax = s32(c.vel_a[63:32]);  vay = s32(c.vel_a[31:0]);
         vbx = s32(c.vel_b[63:32]);  vby = s32(c.vel_b[31:0]);
         cx = s32(c.normal[63:32]);  cy = s32(c.normal[31:0]);
         pen = s32(c.pen);
         ima = longint'(c.ima);      imb = longint'(c.imb);
         ra = s32(c.rest_a);         rb = s32(c.rest_b);
         fa = s32(c.fric_a);         fb = s32(c.fric_b);
         lsq = len_sq(cx, cy);
         sum = clamp32(ima + imb);
         if (c.trig || lsq <= MIN_LSQ || sum <= 0) begin
            o.vel_a = c.vel_a;
            o.vel_b = c.vel_b;
            o.shift_a = '0;
            o.shift_b = '0;
            o.resolved = 1'b0;
            return o;
         end
         unit_vec(cx, cy, lsq, nx, ny);
         van = dot(clamp32(vbx - vax), clamp32(vby - vay), nx, ny);
         // Approaching bodies get a restitution impulse, then clamped friction.
         if (van <= 0) begin
            e = (ra < rb) ? ra : rb;
            j = fdiv(clamp32(-fmul(clamp32(ONE + e), van)), sum);
            ix = fmul(nx, j);
            iy = fmul(ny, j);
            vax = clamp32(vax - fmul(ix, ima));
            vay = clamp32(vay - fmul(iy, ima));
            vbx = clamp32(vbx + fmul(ix, imb));
            vby = clamp32(vby + fmul(iy, imb));
            rx = clamp32(vbx - vax);
            ry = clamp32(vby - vay);
            d = dot(rx, ry, nx, ny);
            tx = clamp32(rx - fmul(nx, d));
            ty = clamp32(ry - fmul(ny, d));
            tl = len_sq(tx, ty);
            if (tl > MIN_LSQ) begin
               unit_vec(tx, ty, tl, ux, uy);
               fm = fdiv(clamp32(-dot(rx, ry, ux, uy)), sum);
               prod = fa * fb;
               mu = (prod <= 0) ? 0 : clamp32(longint'(root(longint'(prod))));
               mx = fmul(j, mu);
               // With a negative bound the lower test wins, as in the block.
               if (fm < clamp32(-mx)) fm = clamp32(-mx);
               else if (fm > mx) fm = mx;
               ix = fmul(ux, fm);
               iy = fmul(uy, fm);
               vax = clamp32(vax - fmul(ix, ima));
               vay = clamp32(vay - fmul(iy, ima));
               vbx = clamp32(vbx + fmul(ix, imb));
               vby = clamp32(vby + fmul(iy, imb));
            end
         end
         depth = clamp32(pen - SLOP);
         if (depth < 0) depth = 0;
         cc = fmul(fdiv(depth, sum), PCT);
         kx = fmul(nx, cc);
         ky = fmul(ny, cc);
         sax = fmul(clamp32(-kx), ima);
         say = fmul(clamp32(-ky), ima);
         sbx = fmul(kx, imb);
         sby = fmul(ky, imb);
         if (c.frz[FRZ_AX]) sax = 0;
         if (c.frz[FRZ_AY]) say = 0;
         if (c.frz[FRZ_BX]) sbx = 0;
         if (c.frz[FRZ_BY]) sby = 0;
         o.vel_a = pack2(vax, vay);
         o.vel_b = pack2(vbx, vby);
         o.shift_a = pack2(sax, say);
         o.shift_b = pack2(sbx, sby);
         o.resolved = 1'b1;
         return o;
      endfunction

      function void note_contact(contact_type c);
         pending_q.insert(pending_q.size(), resolve(c));
      endfunction

      function void check_outcome(logic [255:0] data, logic flag);
         outcome_type want;
         if (pending_q.size() == 0) begin
            $error("unexpected result item with nothing outstanding");
            errors++;
            return;
         end
         want = pending_q.pop_front();
         if (data[63:0] !== want.vel_a) begin
            $error("new_vel_a: expected %h, got %h", want.vel_a, data[63:0]);
            errors++;
         end
         if (data[127:64] !== want.vel_b) begin
            $error("new_vel_b: expected %h, got %h", want.vel_b, data[127:64]);
            errors++;
         end
         if (data[191:128] !== want.shift_a) begin
            $error("shift_a: expected %h, got %h", want.shift_a, data[191:128]);
            errors++;
         end
         if (data[255:192] !== want.shift_b) begin
            $error("shift_b: expected %h, got %h", want.shift_b, data[255:192]);
            errors++;
         end
         if (flag !== want.resolved) begin
            $error("resolved: expected %b, got %b", want.resolved, flag);
            errors++;
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [423:0] req_tdata;
   logic [0:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [255:0] rsp_tdata;
   logic [0:0]   rsp_tuser;

   contact_impulse_resolver_top #(.FRAC_BITS(FB)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   contact_scoreboard board = new();

   // Idle percentages for the current phase, and the long receiver hold-off request.
   int     send_idle_pct = 0;
   int     recv_stall_pct = 0;
   bit     hold_request = 0;
   longint cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog: a hung pipeline ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("contact_impulse_resolver_top verification failed");
         $finish;
      end
   end

   // Receiver: random stalls per phase, plus one long hold-off counted here.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && hold_left == 0) begin
            hold_left = 800;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready = 1'b0;
         end else begin
            rsp_tready = ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Every accepted result item goes straight to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_outcome(rsp_tdata, rsp_tuser[0]);
      end
   end

   function automatic logic [423:0] pack_contact(contact_type c);
      return {6'b0, c.frz, c.fric_b, c.fric_a, c.rest_b, c.rest_a, c.imb, c.ima,
              c.pen, c.normal, c.vel_b, c.vel_a};
   endfunction

   // Offers one contact, with random idle cycles ahead of it, until it is taken.
   task automatic offer_contact(contact_type c);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = pack_contact(c);
      req_tuser = c.trig;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_contact(c);
   endtask

   function automatic logic [31:0] rand_scaled(int lo, int hi);
      return 32'($signed(lo + int'($urandom_range(hi - lo))));
   endfunction

   // Mostly plausible contacts, the rest raw bits to reach every field extreme.
   function automatic contact_type random_contact();
      contact_type c;
      if ($urandom_range(99) < 25) begin
         c.vel_a = {$urandom, $urandom};
         c.vel_b = {$urandom, $urandom};
         c.normal = {$urandom, $urandom};
         c.pen = $urandom;
         c.ima = 31'($urandom);
         c.imb = 31'($urandom);
         c.rest_a = $urandom;
         c.rest_b = $urandom;
         c.fric_a = $urandom;
         c.fric_b = $urandom;
         c.frz = 4'($urandom);
         c.trig = 1'($urandom);
      end else begin
         c.vel_a = {rand_scaled(-1 << 21, 1 << 21), rand_scaled(-1 << 21, 1 << 21)};
         c.vel_b = {rand_scaled(-1 << 21, 1 << 21), rand_scaled(-1 << 21, 1 << 21)};
         c.normal = {rand_scaled(-1 << 18, 1 << 18), rand_scaled(-1 << 18, 1 << 18)};
         c.pen = rand_scaled(-1 << 14, 1 << 18);
         c.ima = ($urandom_range(9) == 0) ? 31'd0 : 31'($urandom_range(1 << 18));
         c.imb = ($urandom_range(9) == 0) ? 31'd0 : 31'($urandom_range(1 << 18));
         c.rest_a = rand_scaled(-1 << 14, 1 << 16);
         c.rest_b = rand_scaled(-1 << 14, 1 << 16);
         c.fric_a = rand_scaled(-1 << 14, 1 << 17);
         c.fric_b = rand_scaled(-1 << 14, 1 << 17);
         c.frz = ($urandom_range(1) == 0) ? 4'd0 : 4'($urandom);
         c.trig = ($urandom_range(9) == 0);
      end
      return c;
   endfunction

   // A sound approaching contact that later directed cases tweak.
   function automatic contact_type base_contact();
      contact_type c;
      c.vel_a = {32'sh0002_0000, 32'sh0000_8000};
      c.vel_b = {-32'sh0001_0000, 32'sh0000_0000};
      c.normal = {32'sh0003_0000, 32'sh0000_0000};
      c.pen = 32'sh0000_4000;
      c.ima = 31'h0001_0000;
      c.imb = 31'h0000_8000;
      c.rest_a = 32'sh0000_8000;
      c.rest_b = 32'sh0000_4000;
      c.fric_a = 32'sh0000_8000;
      c.fric_b = 32'sh0000_8000;
      c.frz = 4'd0;
      c.trig = 1'b0;
      return c;
   endfunction

   task automatic run_directed();
      contact_type c;
      offer_contact(base_contact());
      c = base_contact(); c.trig = 1'b1; offer_contact(c);
      // A normal that is exactly zero, and one just at the short-length bound.
      c = base_contact(); c.normal = '0; offer_contact(c);
      c = base_contact(); c.normal = {32'sd65, 32'sd5}; offer_contact(c);
      c = base_contact(); c.normal = {32'sd65, 32'sd10}; offer_contact(c);
      c = base_contact(); c.ima = '0; c.imb = '0; offer_contact(c);
      // Mass sum that saturates at the largest positive value.
      c = base_contact(); c.ima = '1; c.imb = '1; offer_contact(c);
      // Receding bodies: only the position correction applies.
      c = base_contact(); c.vel_a = {-32'sh0002_0000, 32'sh0}; c.vel_b = {32'sh0002_0000, 32'sh0};
      offer_contact(c);
      // Pure normal approach gives a tangent too short for friction.
      c = base_contact(); c.vel_a = {32'sh0002_0000, 32'sh0}; offer_contact(c);
      // Friction coefficients of opposite sign combine to zero.
      c = base_contact(); c.fric_a = -32'sh0000_8000; offer_contact(c);
      // A negative restitution turns the friction bound negative.
      c = base_contact(); c.rest_a = -32'sh0004_0000; offer_contact(c);
      for (int f = 1; f < 16; f += 5) begin
         c = base_contact(); c.frz = 4'(f); offer_contact(c);
      end
      c = base_contact(); c.frz = 4'hf; offer_contact(c);
      c = base_contact(); c.pen = 32'sh8000_0000; offer_contact(c);
      c = base_contact(); c.pen = 32'sh7fff_ffff; offer_contact(c);
      c = base_contact(); c.vel_a = {32'sh7fff_ffff, 32'sh8000_0000};
      c.vel_b = {32'sh8000_0000, 32'sh7fff_ffff}; c.normal = '1; offer_contact(c);
      c = base_contact(); c.normal = {32'sh7fff_ffff, 32'sh8000_0000}; offer_contact(c);
      c = base_contact(); c.fric_a = 32'sh7fff_ffff; c.fric_b = 32'sh7fff_ffff;
      c.rest_a = 32'sh7fff_ffff; c.rest_b = 32'sh7fff_ffff; offer_contact(c);
      c = base_contact(); c.fric_a = 32'sh8000_0000; c.fric_b = 32'sh8000_0000;
      c.rest_a = 32'sh8000_0000; c.rest_b = 32'sh8000_0000; offer_contact(c);
   endtask

   initial begin
      int pcts[4][2];
      pcts = '{'{0, 0}, '{63, 0}, '{0, 63}, '{35, 35}};
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      run_directed();
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = pcts[p][0];
         recv_stall_pct = pcts[p][1];
         // In the full-rate phase, hold the receiver off so the pipeline backs up.
         if (p == 0) hold_request = 1;
         for (int n = 0; n < 110; n++) offer_contact(random_contact());
      end
      @(negedge clock);
      req_tvalid = 1'b0;

      while (board.pending_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.pending_q.size() == 0) begin
         $display("contact_impulse_resolver_top verification clean");
      end else begin
         $display("contact_impulse_resolver_top verification failed");
      end
      $finish;
   end
endmodule

### filelist.f
+incdir+rtl/core
rtl/core/cir_pkg.sv
rtl/core/cir_dly.sv
rtl/core/cir_sqrt.sv
rtl/core/cir_div.sv
rtl/core/contact_impulse_resolver_top.sv
test/tb.sv
